>>> hdl/lpse_pkg.sv
// Shared types, constants and the nibble encoding function for the LED pixel encoder.
`timescale 1ns / 1ps

package lpse_pkg;

  localparam int PIXELS_PER_PACKET = 5;
  localparam int BITS_PER_PIXEL    = 96;
  localparam int CNT_W             = $clog2(PIXELS_PER_PACKET + 1);
  localparam int BITS_W            = $clog2(PIXELS_PER_PACKET * BITS_PER_PIXEL + 1);

  localparam int CHAN_W  = 8;
  localparam int WORD_W  = 4 * CHAN_W;
  localparam int PCT_W   = 8;
  localparam int IDX_W   = 2;
  localparam int ORDER_W = 3;

  localparam int FULL_POWER = 100;
  // floor(x / 100) == (x * 5243) >> 19 for every x up to 255 * 99
  localparam int RECIP_MUL   = 5243;
  localparam int RECIP_SHIFT = 19;
  localparam int SCALE_W     = RECIP_SHIFT;
  localparam int PROD_W      = SCALE_W + CHAN_W;

  localparam logic [3:0] NIBBLE_ONE  = 4'b1100;
  localparam logic [3:0] NIBBLE_ZERO = 4'b1000;

  // register indexes
  localparam logic [IDX_W-1:0] REG_COLOR_ORDER   = 2'd0;
  localparam logic [IDX_W-1:0] REG_POWER_PERCENT = 2'd1;

  // channel orders
  localparam logic [ORDER_W-1:0] ORDER_RGB = 3'd0;
  localparam logic [ORDER_W-1:0] ORDER_BGR = 3'd1;
  localparam logic [ORDER_W-1:0] ORDER_BRG = 3'd2;
  localparam logic [ORDER_W-1:0] ORDER_GBR = 3'd3;
  localparam logic [ORDER_W-1:0] ORDER_GRB = 3'd4;
  localparam logic [ORDER_W-1:0] ORDER_RBG = 3'd5;

  typedef struct packed {
    logic [ORDER_W-1:0] color_order;
    logic               full_power;
    logic [SCALE_W-1:0] scale;       // power_percent * RECIP_MUL
  } lpse_cfg_t;

  // bit k of the byte becomes nibble k
  function automatic logic [WORD_W-1:0] encode_byte(input logic [CHAN_W-1:0] v);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int k = 0; k < CHAN_W; k++) begin
      w[4*k +: 4] = v[k] ? NIBBLE_ONE : NIBBLE_ZERO;
    end
    return w;
  endfunction

endpackage

>>> hdl/lpse_cfg_regs.sv
// Configuration registers; the brightness scale factor is precomputed at write time.
`timescale 1ns / 1ps

module lpse_cfg_regs import lpse_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [IDX_W-1:0]   cfg_index_i,
  input  logic [PCT_W-1:0]   cfg_data_i,
  output lpse_cfg_t          cfg_o
);

  logic [ORDER_W-1:0] color_order_q;
  logic               full_power_q;
  logic [SCALE_W-1:0] scale_q;
  logic [SCALE_W-1:0] scale_d;
  logic               wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign scale_d     = SCALE_W'({{(SCALE_W-PCT_W){1'b0}}, cfg_data_i} * SCALE_W'(RECIP_MUL));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_order_q <= ORDER_RGB;
      full_power_q  <= 1'b1;
      scale_q       <= '0;
    end else if (wr) begin
      case (cfg_index_i)
        REG_COLOR_ORDER: begin
          color_order_q <= cfg_data_i[ORDER_W-1:0];
        end
        REG_POWER_PERCENT: begin
          full_power_q <= (cfg_data_i >= PCT_W'(FULL_POWER));
          scale_q      <= scale_d;
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg_o.color_order = color_order_q;
  assign cfg_o.full_power  = full_power_q;
  assign cfg_o.scale       = scale_q;

endmodule

>>> hdl/lpse_pixel_enc.sv
// Pixel datapath: brightness scaling, channel reorder and nibble encoding.
`timescale 1ns / 1ps

module lpse_pixel_enc import lpse_pkg::*; (
  input  lpse_cfg_t           cfg_i,
  input  logic [CHAN_W-1:0]   red_i,
  input  logic [CHAN_W-1:0]   green_i,
  input  logic [CHAN_W-1:0]   blue_i,
  output logic [WORD_W-1:0]   word_first_o,
  output logic [WORD_W-1:0]   word_second_o,
  output logic [WORD_W-1:0]   word_third_o
);

  logic [PROD_W-1:0] prod_r, prod_g, prod_b;
  logic [CHAN_W-1:0] r, g, b;
  logic [CHAN_W-1:0] c0, c1, c2;

  assign prod_r = {{SCALE_W{1'b0}}, red_i}   * {{CHAN_W{1'b0}}, cfg_i.scale};
  assign prod_g = {{SCALE_W{1'b0}}, green_i} * {{CHAN_W{1'b0}}, cfg_i.scale};
  assign prod_b = {{SCALE_W{1'b0}}, blue_i}  * {{CHAN_W{1'b0}}, cfg_i.scale};

  assign r = cfg_i.full_power ? red_i   : prod_r[PROD_W-1 -: CHAN_W];
  assign g = cfg_i.full_power ? green_i : prod_g[PROD_W-1 -: CHAN_W];
  assign b = cfg_i.full_power ? blue_i  : prod_b[PROD_W-1 -: CHAN_W];

  // unused order codes fall back to RGB
  always_comb begin
    case (cfg_i.color_order)
      ORDER_BGR: begin c0 = b; c1 = g; c2 = r; end
      ORDER_BRG: begin c0 = b; c1 = r; c2 = g; end
      ORDER_GBR: begin c0 = g; c1 = b; c2 = r; end
      ORDER_GRB: begin c0 = g; c1 = r; c2 = b; end
      ORDER_RBG: begin c0 = r; c1 = b; c2 = g; end
      default:   begin c0 = r; c1 = g; c2 = b; end
    endcase
  end

  assign word_first_o  = encode_byte(c0);
  assign word_second_o = encode_byte(c1);
  assign word_third_o  = encode_byte(c2);

endmodule

>>> hdl/led_pixel_spi_bit_encoder.sv
// Top level: input register, pixel datapath, packet counter and result register.
// A pixel passes from the input register into the result register when the output is free.
// Throughput: one pixel per cycle unless stalled; one 8x19 scale multiply per channel.
// An output stall holds both stages; input ready drops only when both stages are full.
// Reset (async, active low) clears valids and the packet count, sets order RGB, full power.
`timescale 1ns / 1ps

module led_pixel_spi_bit_encoder import lpse_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IDX_W-1:0]    cfg_index_i,
  input  logic [PCT_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [CHAN_W-1:0]   red_i,
  input  logic [CHAN_W-1:0]   green_i,
  input  logic [CHAN_W-1:0]   blue_i,
  input  logic                last_pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [WORD_W-1:0]   word_first_o,
  output logic [WORD_W-1:0]   word_second_o,
  output logic [WORD_W-1:0]   word_third_o,
  output logic                packet_end_o,
  output logic [BITS_W-1:0]   packet_bits_o
);

  lpse_cfg_t cfg;

  logic              s1_valid_q;
  logic [CHAN_W-1:0] red_q, green_q, blue_q;
  logic              last_q;

  logic              out_valid_q;
  logic [WORD_W-1:0] w0_q, w1_q, w2_q;
  logic [WORD_W-1:0] w0_d, w1_d, w2_d;
  logic              pend_q, pend_d;
  logic [BITS_W-1:0] pbits_q, pbits_d;

  logic [CNT_W-1:0]  pix_cnt_q, pix_cnt_d;
  logic [CNT_W-1:0]  count;
  logic              out_free, s1_move, in_take;

  lpse_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lpse_pixel_enc u_enc (
    .cfg_i         (cfg),
    .red_i         (red_q),
    .green_i       (green_q),
    .blue_i        (blue_q),
    .word_first_o  (w0_d),
    .word_second_o (w1_d),
    .word_third_o  (w2_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_move    = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign in_take    = in_valid_i && in_ready_o;

  // packet bookkeeping
  assign count     = pix_cnt_q + CNT_W'(1);
  assign pend_d    = last_q || (count >= CNT_W'(PIXELS_PER_PACKET));
  assign pbits_d   = BITS_W'(count) * BITS_W'(BITS_PER_PIXEL);
  assign pix_cnt_d = pend_d ? '0 : count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pix_cnt_q   <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_move) begin
        pix_cnt_q <= pix_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
      last_q  <= last_pixel_i;
    end
    if (s1_move) begin
      w0_q    <= w0_d;
      w1_q    <= w1_d;
      w2_q    <= w2_d;
      pend_q  <= pend_d;
      pbits_q <= pbits_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign word_first_o  = w0_q;
  assign word_second_o = w1_q;
  assign word_third_o  = w2_q;
  assign packet_end_o  = pend_q;
  assign packet_bits_o = pbits_q;

  // open packet never reaches full size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_cnt_q < CNT_W'(PIXELS_PER_PACKET))
    else $error("packet count out of range");

  // a held result that closes its packet leaves the count at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && pend_q |-> pix_cnt_q == '0)
    else $error("count not cleared after packet end");

  // a held result inside a packet matches the running count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pend_q |-> BITS_W'(pix_cnt_q) * BITS_W'(BITS_PER_PIXEL) == pbits_q)
    else $error("packet bits disagree with count");

  // input stalls only when the input stage and the result register both hold a pixel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled without backpressure");

  // a stalled result moves nothing into the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(pbits_q) && $stable(pix_cnt_q))
    else $error("result register changed under stall");

endmodule

>>> tb/testbench.sv
// Self-checking bench for the LED pixel SPI bit encoder: pixel stream, register writes, packets.
`timescale 1ns / 1ps

module testbench;
  import lpse_pkg::*;

  localparam int RESET_CYCLES = 6;
  localparam int STALL_LIMIT  = 1000;
  localparam int LONG_HOLD    = 120;
  localparam int HOLD_AT_BEAT = 200;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 70;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } pixel_t;

  typedef struct packed {
    logic [WORD_W-1:0] word_first;
    logic [WORD_W-1:0] word_second;
    logic [WORD_W-1:0] word_third;
    logic              packet_end;
    logic [BITS_W-1:0] packet_bits;
  } spi_words_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IDX_W-1:0]  cfg_index_i = '0;
  logic [PCT_W-1:0]  cfg_data_i  = '0;
  logic              in_valid_i  = 1'b0;
  logic              in_ready_o;
  logic [CHAN_W-1:0] red_i       = '0;
  logic [CHAN_W-1:0] green_i     = '0;
  logic [CHAN_W-1:0] blue_i      = '0;
  logic              last_pixel_i = 1'b0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [WORD_W-1:0] word_first_o;
  logic [WORD_W-1:0] word_second_o;
  logic [WORD_W-1:0] word_third_o;
  logic              packet_end_o;
  logic [BITS_W-1:0] packet_bits_o;

  led_pixel_spi_bit_encoder dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  pixel_t     pixel_q[$];
  spi_words_t expected_q[$];

  // shadow of the block's registers and packet state
  logic [ORDER_W-1:0] shadow_order = ORDER_RGB;
  logic [PCT_W-1:0]   shadow_power = PCT_W'(FULL_POWER);
  int                 open_pixels  = 0;

  int mismatch_count = 0;
  bit tx_no_idle = 1'b0;
  bit rx_no_idle = 1'b0;

  task automatic report(input string msg);
    mismatch_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic logic [CHAN_W-1:0] dim_channel(input logic [CHAN_W-1:0] c);
    int scaled;
    scaled = int'(c);
    if (int'(shadow_power) < FULL_POWER) scaled = scaled * int'(shadow_power) / FULL_POWER;
    return scaled[CHAN_W-1:0];
  endfunction

  // shift nibbles in from the top bit down so bit 0 lands in the low nibble
  function automatic logic [WORD_W-1:0] spi_nibbles(input logic [CHAN_W-1:0] v);
    logic [WORD_W-1:0] w;
    w = '0;
    for (int k = CHAN_W - 1; k >= 0; k--) begin
      w = {w[WORD_W-5:0], (v[k] ? NIBBLE_ONE : NIBBLE_ZERO)};
    end
    return w;
  endfunction

  function automatic void predict_pixel(input pixel_t p);
    logic [CHAN_W-1:0] r, g, b, c0, c1, c2;
    spi_words_t w;
    int count;
    r = dim_channel(p.red);
    g = dim_channel(p.green);
    b = dim_channel(p.blue);
    case (shadow_order)
      ORDER_BGR: begin c0 = b; c1 = g; c2 = r; end
      ORDER_BRG: begin c0 = b; c1 = r; c2 = g; end
      ORDER_GBR: begin c0 = g; c1 = b; c2 = r; end
      ORDER_GRB: begin c0 = g; c1 = r; c2 = b; end
      ORDER_RBG: begin c0 = r; c1 = b; c2 = g; end
      default:   begin c0 = r; c1 = g; c2 = b; end  // unused codes fall back to RGB
    endcase
    count         = open_pixels + 1;
    w.word_first  = spi_nibbles(c0);
    w.word_second = spi_nibbles(c1);
    w.word_third  = spi_nibbles(c2);
    w.packet_end  = p.last || count >= PIXELS_PER_PACKET;
    w.packet_bits = BITS_W'(count * BITS_PER_PIXEL);
    open_pixels   = w.packet_end ? 0 : count;
    expected_q.push_back(w);
  endfunction

  // pixel sender
  pixel_t tx_pixel;
  int     tx_gap = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_pixel('{red_i, green_i, blue_i, last_pixel_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap != 0) begin
          tx_gap     <= tx_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pixel_q.size() != 0) begin
          tx_pixel     = pixel_q.pop_front();
          in_valid_i   <= 1'b1;
          red_i        <= tx_pixel.red;
          green_i      <= tx_pixel.green;
          blue_i       <= tx_pixel.blue;
          last_pixel_i <= tx_pixel.last;
          tx_gap       <= tx_no_idle ? 0 : $urandom_range(0, 19);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result receiver and checker
  spi_words_t want;
  int         results_seen = 0;
  int         rx_wait = 0;
  bit         hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          want = expected_q.pop_front();
          if (word_first_o !== want.word_first)
            report($sformatf("word_first %h, expected %h", word_first_o, want.word_first));
          if (word_second_o !== want.word_second)
            report($sformatf("word_second %h, expected %h", word_second_o, want.word_second));
          if (word_third_o !== want.word_third)
            report($sformatf("word_third %h, expected %h", word_third_o, want.word_third));
          if (packet_end_o !== want.packet_end)
            report($sformatf("packet_end %b, expected %b", packet_end_o, want.packet_end));
          if (packet_bits_o !== want.packet_bits)
            report($sformatf("packet_bits %0d, expected %0d", packet_bits_o, want.packet_bits));
        end
        rx_wait = rx_no_idle ? 0 : $urandom_range(0, 19);
      end
      // one long back-pressure window so the pipeline fills and stalls its input
      if (!hold_done && results_seen == HOLD_AT_BEAT) begin
        hold_done = 1'b1;
        rx_wait   = LONG_HOLD;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("led_pixel_spi_bit_encoder: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PCT_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_COLOR_ORDER) shadow_order = data[ORDER_W-1:0];
    else if (idx == REG_POWER_PERCENT) shadow_power = data;
  endtask

  // wait until every queued pixel has come back as a result; polled at the
  // falling edge so the sender's updates from the rising edge have settled
  task automatic drain_pixels();
    while (pixel_q.size() != 0 || in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CHAN_W-1:0] pick_channel();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return CHAN_W'($urandom);
    endcase
  endfunction

  function automatic pixel_t random_pixel();
    return '{pick_channel(), pick_channel(), pick_channel(), ($urandom_range(0, 5) == 0)};
  endfunction

  function automatic logic [PCT_W-1:0] order_write(input int order);
    // upper data bits are noise for the order register
    return {PCT_W'($urandom) & ~PCT_W'(7)} | PCT_W'(order);
  endfunction

  initial begin
    logic [PCT_W-1:0] power;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset registers: single-pixel frame, a full packet, then a short frame
    pixel_q.push_back('{8'h00, 8'h00, 8'h00, 1'b1});
    pixel_q.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b0});
    pixel_q.push_back('{8'hAA, 8'h55, 8'h0F, 1'b0});
    pixel_q.push_back('{8'h55, 8'hAA, 8'hF0, 1'b0});
    pixel_q.push_back('{8'h01, 8'h80, 8'h7F, 1'b0});
    pixel_q.push_back('{8'hFE, 8'h00, 8'hFF, 1'b0});
    pixel_q.push_back('{8'h12, 8'h34, 8'h56, 1'b0});
    pixel_q.push_back('{8'hFF, 8'h00, 8'h80, 1'b1});
    drain_pixels();

    // every channel order other than RGB, the two unused codes included
    for (int order = ORDER_W'(1); order < 8; order++) begin
      write_reg(REG_COLOR_ORDER, order_write(order));
      pixel_q.push_back('{8'h11, 8'h22, 8'h44, 1'b0});
      pixel_q.push_back('{8'hC3, 8'h5A, 8'h0F, 1'b1});
      drain_pixels();
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       power = 8'd0;
        1:       power = 8'd99;
        2:       power = 8'd100;
        3:       power = 8'd255;
        4:       power = 8'd1;
        default: power = PCT_W'($urandom);
      endcase
      write_reg(REG_COLOR_ORDER, order_write($urandom_range(0, 7)));
      write_reg(REG_POWER_PERCENT, power);
      tx_no_idle = (phase % 3 == 1);
      rx_no_idle = (phase % 4 == 1);
      for (int n = 0; n < PHASE_ITEMS; n++) pixel_q.push_back(random_pixel());
      drain_pixels();
    end

    repeat (10) @(posedge clk_i);
    if (expected_q.size() != 0) report($sformatf("%0d results never arrived", expected_q.size()));
    if (mismatch_count == 0) begin
      $display("led_pixel_spi_bit_encoder: match");
    end else begin
      $display("led_pixel_spi_bit_encoder: mismatch");
    end
    $finish;
  end

endmodule
